// ===== rtl/kalc_pkg.sv =====
// Package for the key autorepeat level control core.
// Holds the word layouts, state and configuration types, and codes.
// No dependencies.
package kalc_pkg;

   localparam int REQ_W   = 104;
   localparam int REQ_USER_W = 2;
   localparam int REQ_FIELDS_W = 102;
   localparam int RSP_W   = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_W   = 16;

   localparam logic [15:0] EVENT_KEY_TYPE = 16'd1;
   localparam logic [31:0] KEY_VALUE_TOP  = 32'd2;

   // Item kinds carried in the mode field.
   typedef enum logic [1:0] {
      MODE_POLL_START = 2'd0,
      MODE_KEY_EVENT  = 2'd1,
      MODE_POLL_END   = 2'd2
   } mode_type;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CFG_MENU_KEY_CODE  = 3'd0,
      CFG_PLUS_KEY_CODE  = 3'd1,
      CFG_MINUS_KEY_CODE = 3'd2,
      CFG_FIRST_DELAY_MS = 3'd3,
      CFG_REPEAT_STEP_MS = 3'd4,
      CFG_STALE_GAP_MS   = 3'd5,
      CFG_VOLUME_TOP     = 3'd6,
      CFG_BRIGHTNESS_TOP = 3'd7
   } cfg_index_type;

   typedef struct packed {
      logic [9:0]  menu_key_code;
      logic [9:0]  plus_key_code;
      logic [9:0]  minus_key_code;
      logic [15:0] first_delay_ms;
      logic [15:0] repeat_step_ms;
      logic [15:0] stale_gap_ms;
      logic [5:0]  volume_top;
      logic [5:0]  brightness_top;
   } cfg_type;

   // Input word as registered: mode from tuser in the lowest bits, then the
   // tdata fields from the lowest bit up.
   typedef struct packed {
      logic [5:0]         brightness_in;
      logic [5:0]         volume_in;
      logic signed [31:0] key_value;
      logic [9:0]         key_code;
      logic [15:0]        event_type;
      logic [31:0]        time_ms;
      logic [1:0]         mode;
   } item_type;

   // Result word, first field in the lowest bits, padded to two bytes.
   typedef struct packed {
      logic [1:0] pad;
      logic       brightness_written;
      logic       volume_written;
      logic [5:0] brightness_out;
      logic [5:0] volume_out;
   } result_type;

   typedef struct packed {
      logic [1:0]  menu_held;
      logic [1:0]  plus_held;
      logic [1:0]  plus_fresh;
      logic [31:0] plus_due;
      logic [1:0]  minus_held;
      logic [1:0]  minus_fresh;
      logic [31:0] minus_due;
      logic [31:0] poll_time;
      logic [31:0] last_poll_time;
      logic        time_known;
      logic        ignoring;
   } state_type;

endpackage

// ===== rtl/kalc_step.sv =====
// Next-state and result logic for one item of the autorepeat core.
// Purely combinational; depends on kalc_pkg.
module kalc_step (
   input  kalc_pkg::cfg_type    cfg,
   input  kalc_pkg::state_type  state,
   input  kalc_pkg::item_type   item,
   output kalc_pkg::state_type  next_state,
   output kalc_pkg::result_type result,
   output logic                 result_valid
);
   import kalc_pkg::*;

   state_type   cur;
   logic [31:0] gap;
   logic [1:0]  val;
   logic        key_ok;
   logic        plus_act;
   logic        minus_act;
   logic [5:0]  vol;
   logic [5:0]  bri;
   logic        vol_w;
   logic        bri_w;

   // Common terms.
   always_comb begin
      gap    = item.time_ms - state.last_poll_time;
      val    = item.key_value[1:0];
      key_ok = !state.ignoring && (item.event_type == EVENT_KEY_TYPE)
               && ($unsigned(item.key_value) <= KEY_VALUE_TOP);
   end

   // Key state after the stale check of a poll end.
   always_comb begin
      cur = state;
      if (state.ignoring) begin
         cur.menu_held   = 2'd0;
         cur.plus_held   = 2'd0;
         cur.plus_fresh  = 2'd0;
         cur.plus_due    = 32'd0;
         cur.minus_held  = 2'd0;
         cur.minus_fresh = 2'd0;
         cur.minus_due   = 32'd0;
      end
      plus_act  = (cur.plus_fresh != 2'd0)
                  || ((cur.plus_held != 2'd0) && (state.poll_time >= cur.plus_due));
      minus_act = (cur.minus_fresh != 2'd0)
                  || ((cur.minus_held != 2'd0) && (state.poll_time >= cur.minus_due));
   end

   // Per-kind update.
   always_comb begin
      next_state   = state;
      result       = '0;
      result_valid = 1'b0;
      vol          = item.volume_in;
      bri          = item.brightness_in;
      vol_w        = 1'b0;
      bri_w        = 1'b0;
      case (item.mode)
         MODE_POLL_START: begin
            next_state.poll_time = item.time_ms;
            if (!state.time_known) begin
               next_state.time_known     = 1'b1;
               next_state.last_poll_time = item.time_ms;
            end else if (gap > {16'd0, cfg.stale_gap_ms}) begin
               next_state.ignoring = 1'b1;
            end
         end
         MODE_KEY_EVENT: begin
            if (key_ok) begin
               if (item.key_code == cfg.menu_key_code) begin
                  next_state.menu_held = val;
               end else if (item.key_code == cfg.plus_key_code) begin
                  next_state.plus_held  = val;
                  next_state.plus_fresh = val;
                  if (val != 2'd0) begin
                     next_state.plus_due = state.poll_time + {16'd0, cfg.first_delay_ms};
                  end
               end else if (item.key_code == cfg.minus_key_code) begin
                  next_state.minus_held  = val;
                  next_state.minus_fresh = val;
                  if (val != 2'd0) begin
                     next_state.minus_due = state.poll_time + {16'd0, cfg.first_delay_ms};
                  end
               end
            end
         end
         MODE_POLL_END: begin
            next_state = cur;
            // Increase step first.
            if (plus_act) begin
               if (cur.menu_held != 2'd0) begin
                  if (bri < cfg.brightness_top) begin
                     bri   = bri + 6'd1;
                     bri_w = 1'b1;
                  end
               end else if (vol < cfg.volume_top) begin
                  vol   = vol + 6'd1;
                  vol_w = 1'b1;
               end
               if (cur.plus_fresh != 2'd0) begin
                  next_state.plus_fresh = 2'd0;
               end else begin
                  next_state.plus_due = cur.plus_due + {16'd0, cfg.repeat_step_ms};
               end
            end
            // Then the decrease step, on the already stepped levels.
            if (minus_act) begin
               if (cur.menu_held != 2'd0) begin
                  if (bri != 6'd0) begin
                     bri   = bri - 6'd1;
                     bri_w = 1'b1;
                  end
               end else if (vol != 6'd0) begin
                  vol   = vol - 6'd1;
                  vol_w = 1'b1;
               end
               if (cur.minus_fresh != 2'd0) begin
                  next_state.minus_fresh = 2'd0;
               end else begin
                  next_state.minus_due = cur.minus_due + {16'd0, cfg.repeat_step_ms};
               end
            end
            next_state.last_poll_time = state.poll_time;
            next_state.ignoring       = 1'b0;
            result.volume_out         = vol;
            result.brightness_out     = bri;
            result.volume_written     = vol_w;
            result.brightness_written = bri_w;
            result_valid              = 1'b1;
         end
         default: begin
            // Unused kind: no change, no result.
         end
      endcase
   end

endmodule

// ===== rtl/key_autorepeat_level_control_core.sv =====
// Key autorepeat level control core: input register, one pass of step logic,
// result register. Depends on kalc_pkg and kalc_step.
// A poll end word passes the input register and step logic into the result register on rsp.
// Throughput: one word per cycle; the input stage stalls only when it holds a
// poll end and the result register is full and not being taken.
// Reset (synchronous, active high) clears all state and both stages, loads register defaults.
module key_autorepeat_level_control_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // mode
   input  logic [kalc_pkg::REQ_USER_W-1:0] req_tuser,
   // time_ms, event_type, key_code, key_value, volume_in, brightness_in, zero pad
   input  logic [kalc_pkg::REQ_W-1:0]      req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // volume_out, brightness_out, volume_written, brightness_written, zero pad
   output logic [kalc_pkg::RSP_W-1:0]      rsp_tdata,
   input  logic                            csr_we,
   input  logic [kalc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [kalc_pkg::CSR_W-1:0]      csr_wdata
);
   import kalc_pkg::*;

   cfg_type    cfg_ff;
   state_type  state_ff;
   state_type  state_in;
   logic       s1_valid_ff;
   item_type   s1_item_ff;
   logic       rsp_valid_ff;
   result_type rsp_data_ff;
   result_type step_result;
   logic       step_result_valid;
   logic       s1_fire;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.menu_key_code  <= 10'd0;
         cfg_ff.plus_key_code  <= 10'd0;
         cfg_ff.minus_key_code <= 10'd0;
         cfg_ff.first_delay_ms <= 16'd300;
         cfg_ff.repeat_step_ms <= 16'd100;
         cfg_ff.stale_gap_ms   <= 16'd1000;
         cfg_ff.volume_top     <= 6'd20;
         cfg_ff.brightness_top <= 6'd10;
      end else if (csr_we) begin
         case (csr_index)
            CFG_MENU_KEY_CODE:  cfg_ff.menu_key_code  <= csr_wdata[9:0];
            CFG_PLUS_KEY_CODE:  cfg_ff.plus_key_code  <= csr_wdata[9:0];
            CFG_MINUS_KEY_CODE: cfg_ff.minus_key_code <= csr_wdata[9:0];
            CFG_FIRST_DELAY_MS: cfg_ff.first_delay_ms <= csr_wdata;
            CFG_REPEAT_STEP_MS: cfg_ff.repeat_step_ms <= csr_wdata;
            CFG_STALE_GAP_MS:   cfg_ff.stale_gap_ms   <= csr_wdata;
            CFG_VOLUME_TOP:     cfg_ff.volume_top     <= csr_wdata[5:0];
            CFG_BRIGHTNESS_TOP: cfg_ff.brightness_top <= csr_wdata[5:0];
            default: begin
            end
         endcase
      end
   end

   // The input stage drains unless a poll end finds the result register blocked.
   assign s1_fire    = s1_valid_ff
                       && ((s1_item_ff.mode != MODE_POLL_END) || !rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_fire;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_fire) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_item_ff <= item_type'({req_tdata[REQ_FIELDS_W-1:0], req_tuser});
      end
   end

   kalc_step u_step (
      .cfg          (cfg_ff),
      .state        (state_ff),
      .item         (s1_item_ff),
      .next_state   (state_in),
      .result       (step_result),
      .result_valid (step_result_valid)
   );

   // Key and time state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (s1_fire) begin
         state_ff <= state_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_fire && step_result_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && step_result_valid) begin
         rsp_data_ff <= step_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== rtl/kalc_checker.sv =====
// Port-level checks for the key autorepeat level control core, and the bind
// that attaches them. Depends on kalc_pkg.
module kalc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [kalc_pkg::RSP_W-1:0]      rsp_tdata
);
   import kalc_pkg::*;

   result_type rsp_word;
   assign rsp_word = result_type'(rsp_tdata);

   // No result word is left over from before reset.
   a_reset_empty: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_tvalid)
      else $error("result word valid right after reset");

   // A stalled result word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result word changed");

   // The modifier sends both steps of a poll to the same level.
   a_one_level: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_word.volume_written && rsp_word.brightness_written))
      else $error("both levels written in one poll");

   // Pad bits stay zero.
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_word.pad == 2'd0))
      else $error("result pad bits set");

   // With the result register empty, the input side never stalls.
   a_no_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty result register");

endmodule

bind key_autorepeat_level_control_core kalc_checker u_kalc_checker (.*);
